@@ rtl/core/assert_macros.svh @@
// Shared assertion macros for the stencil sweep RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside of reset.
`define ASSERT_IMPL(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Expression must never be true outside of reset.
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    `ASSERT_IMPL(label, clk, rst_n, !(expr), msg)

`endif

@@ rtl/core/eess_pkg.sv @@
package eess_pkg;

    localparam int VALUE_W    = 32;
    localparam int WIDE_W     = 48;
    localparam int PROD_W     = 2 * VALUE_W;
    localparam int FRAC_W     = 16;
    localparam int IDX_W      = 10;
    localparam int MAX_POINTS = 1024;
    localparam int CFG_W      = 31;
    localparam int CFG_IDX_W  = 2;
    localparam int Q_DEPTH    = 2;
    localparam int QP_W       = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int QC_W       = $clog2(Q_DEPTH + 1);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TIME_STEP  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SPACE_STEP = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_SQ     = 2'd2;

    localparam logic [CFG_W-1:0] RST_TIME_STEP  = 31'd655;
    localparam logic [CFG_W-1:0] RST_SPACE_STEP = 31'd6554;
    localparam logic [CFG_W-1:0] RST_INV_SQ     = 31'd6553600;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_POINTS - 1);

    typedef logic signed [VALUE_W-1:0] t_val;
    typedef logic signed [WIDE_W-1:0]  t_wide;

    localparam t_val  Q_HALF  = 32'sd32768;
    localparam t_val  Q_TWO   = 32'sd131072;
    localparam logic signed [PROD_W-1:0] Q_ROUND = 64'sd32768;
    localparam t_wide SAT_HI  = 48'sh0000_7FFF_FFFF;
    localparam t_wide SAT_LO  = 48'shFFFF_8000_0000;

    typedef struct packed {
        logic [CFG_W-1:0] time_step;
        logic [CFG_W-1:0] space_step;
        logic [CFG_W-1:0] inv_sq;
    } t_cfg;

    typedef struct packed {
        t_val old_value;
        t_val diffusion;
        t_val convection;
        t_val reaction;
        t_val forcing;
        logic last_point;
    } t_point;

    typedef struct packed {
        t_val             u_prev;
        t_val             u_mid;
        t_val             u_next;
        t_val             sig;
        t_val             mu;
        t_val             rct;
        t_val             frc;
        logic [IDX_W-1:0] index;
        logic             last;
    } t_job;

    typedef struct packed {
        logic clip;
        t_val val;
    } t_sat;

    function automatic t_sat sat_wide(input t_wide v);
        t_sat s;
        s.clip = 1'b0;
        s.val  = v[VALUE_W-1:0];
        if (v > SAT_HI) begin
            s.clip = 1'b1;
            s.val  = SAT_HI[VALUE_W-1:0];
        end else if (v < SAT_LO) begin
            s.clip = 1'b1;
            s.val  = SAT_LO[VALUE_W-1:0];
        end
        return s;
    endfunction

endpackage

@@ rtl/core/eess_front.sv @@
module eess_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  eess_pkg::t_point i_pt,
    input  logic            i_full,
    output logic            o_push,
    output eess_pkg::t_job  o_job
);
    import eess_pkg::*;

    logic [IDX_W-1:0] r_idx;
    t_val             r_u_prev, r_u_mid, r_sig, r_mu, r_rct, r_frc;
    logic             accept;
    logic             last;

    assign o_ready = !i_full;
    assign accept  = i_valid && o_ready;
    // Force the end of a sweep at the top of the index range.
    assign last    = i_pt.last_point || (r_idx == LAST_IDX);
    assign o_push  = accept && (r_idx >= IDX_W'(2));

    always_comb begin
        o_job.u_prev = r_u_prev;
        o_job.u_mid  = r_u_mid;
        o_job.u_next = i_pt.old_value;
        o_job.sig    = r_sig;
        o_job.mu     = r_mu;
        o_job.rct    = r_rct;
        o_job.frc    = r_frc;
        o_job.index  = r_idx - IDX_W'(1);
        o_job.last   = last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (accept) begin
            r_idx <= last ? '0 : r_idx + IDX_W'(1);
        end
    end

    // Shift the window; a new sweep refills it before any update is issued.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_u_prev <= r_u_mid;
            r_u_mid  <= i_pt.old_value;
            r_sig    <= i_pt.diffusion;
            r_mu     <= i_pt.convection;
            r_rct    <= i_pt.reaction;
            r_frc    <= i_pt.forcing;
        end
    end

endmodule

@@ rtl/core/eess_fifo.sv @@
`include "assert_macros.svh"

module eess_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  eess_pkg::t_job i_job,
    output logic           o_full,
    input  logic           i_pop,
    output eess_pkg::t_job o_job,
    output logic           o_empty
);
    import eess_pkg::*;

    t_job            r_mem [Q_DEPTH];
    logic [QP_W-1:0] r_wr;
    logic [QP_W-1:0] r_rd;
    logic [QC_W-1:0] r_count;

    assign o_full  = (r_count == QC_W'(Q_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_job   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == QP_W'(Q_DEPTH - 1)) ? '0 : r_wr + QP_W'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == QP_W'(Q_DEPTH - 1)) ? '0 : r_rd + QP_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + QC_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - QC_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    `ASSERT_NEVER(a_no_overflow, i_clk, i_rst_n, i_push && o_full, "push into full queue")
    `ASSERT_NEVER(a_no_underflow, i_clk, i_rst_n, i_pop && o_empty, "pop from empty queue")

endmodule

@@ rtl/core/eess_back.sv @@
`include "assert_macros.svh"

module eess_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  eess_pkg::t_cfg               i_cfg,
    input  logic                         i_empty,
    input  eess_pkg::t_job               i_job,
    output logic                         o_pop,
    output logic                         o_valid,
    input  logic                         i_ready,
    output eess_pkg::t_val               o_new_value,
    output logic [eess_pkg::IDX_W-1:0]   o_point_index,
    output logic                         o_sweep_end,
    output logic                         o_saturated
);
    import eess_pkg::*;

    // Microcode steps, executed in order; the multiply steps share one multiplier.
    typedef enum logic [4:0] {
        S_DTSIG = 5'd0,
        S_DTDX  = 5'd1,
        S_CMU   = 5'd2,
        S_CONV  = 5'd3,
        S_DX2   = 5'd4,
        S_AG    = 5'd5,
        S_TDX2  = 5'd6,
        S_REACT = 5'd7,
        S_TWO   = 5'd8,
        S_BETA1 = 5'd9,
        S_BETA2 = 5'd10,
        S_PA    = 5'd11,
        S_PB    = 5'd12,
        S_PC    = 5'd13,
        S_ACC   = 5'd14,
        S_SCL   = 5'd15,
        S_FD    = 5'd16,
        S_RES   = 5'd17
    } t_step;

    t_step r_step;
    logic  r_busy;
    logic  r_phase;
    logic  r_out_valid;
    t_job  r_job;
    logic  r_clip;
    logic signed [PROD_W-1:0] r_prod;
    t_val  r_dt_sig, r_tmp, r_conv, r_dx2, r_alpha, r_gamma, r_react, r_beta;
    t_val  r_pa, r_pb, r_acc;
    t_val  r_out_val;
    logic [IDX_W-1:0] r_out_idx;
    logic  r_out_last, r_out_sat;

    t_val  dt, dx, inv;
    t_val  mul_a, mul_b;
    logic  is_mul;
    logic signed [PROD_W-1:0] prod, rnd;
    t_sat  q, s_alpha, s_gamma, s_beta1, s_beta2, s_acc, s_res;
    logic  mul_wr, add_wr, out_free;

    assign dt  = t_val'({1'b0, i_cfg.time_step});
    assign dx  = t_val'({1'b0, i_cfg.space_step});
    assign inv = t_val'({1'b0, i_cfg.inv_sq});

    always_comb begin
        is_mul = 1'b1;
        mul_a  = '0;
        mul_b  = '0;
        unique case (r_step)
            S_DTSIG: begin mul_a = dt;      mul_b = r_job.sig;    end
            S_DTDX:  begin mul_a = dt;      mul_b = dx;           end
            S_CMU:   begin mul_a = r_tmp;   mul_b = r_job.mu;     end
            S_CONV:  begin mul_a = Q_HALF;  mul_b = r_tmp;        end
            S_DX2:   begin mul_a = dx;      mul_b = dx;           end
            S_TDX2:  begin mul_a = dt;      mul_b = r_dx2;        end
            S_REACT: begin mul_a = r_tmp;   mul_b = r_job.rct;    end
            S_TWO:   begin mul_a = Q_TWO;   mul_b = r_dt_sig;     end
            S_PA:    begin mul_a = r_alpha; mul_b = r_job.u_prev; end
            S_PB:    begin mul_a = r_beta;  mul_b = r_job.u_mid;  end
            S_PC:    begin mul_a = r_gamma; mul_b = r_job.u_next; end
            S_SCL:   begin mul_a = r_acc;   mul_b = inv;          end
            S_FD:    begin mul_a = dt;      mul_b = r_job.frc;    end
            default: is_mul = 1'b0;
        endcase
    end

    assign prod = mul_a * mul_b;
    // Round to nearest, ties toward plus infinity, then clip.
    assign rnd  = r_prod + Q_ROUND;
    assign q    = sat_wide(t_wide'(rnd[PROD_W-1:FRAC_W]));

    assign s_alpha = sat_wide(t_wide'(r_dt_sig) - t_wide'(r_conv));
    assign s_gamma = sat_wide(t_wide'(r_dt_sig) + t_wide'(r_conv));
    assign s_beta1 = sat_wide(t_wide'(r_dx2) - t_wide'(r_tmp));
    assign s_beta2 = sat_wide(t_wide'(r_beta) + t_wide'(r_react));
    assign s_acc   = sat_wide(t_wide'(r_pa) + t_wide'(r_pb) + t_wide'(r_tmp));
    assign s_res   = sat_wide(t_wide'(r_acc) - t_wide'(r_tmp));

    assign o_pop    = !r_busy && !i_empty;
    assign out_free = !r_out_valid || i_ready;
    assign mul_wr   = r_busy && is_mul && r_phase;
    assign add_wr   = r_busy && !is_mul && (r_step != S_RES);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_phase     <= 1'b0;
            r_step      <= S_DTSIG;
            r_out_valid <= 1'b0;
        end else begin
            if (r_busy && (r_step == S_RES) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            if (!r_busy) begin
                if (!i_empty) begin
                    r_busy  <= 1'b1;
                    r_step  <= S_DTSIG;
                    r_phase <= 1'b0;
                end
            end else if (is_mul && !r_phase) begin
                r_phase <= 1'b1;
            end else if (r_step == S_RES) begin
                // Hold the finished result until the output register frees up.
                if (out_free) begin
                    r_busy <= 1'b0;
                end
            end else begin
                r_phase <= 1'b0;
                r_step  <= t_step'(r_step + 5'd1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job  <= i_job;
            r_clip <= 1'b0;
        end
        if (r_busy && is_mul && !r_phase) begin
            r_prod <= prod;
        end
        if (mul_wr) begin
            r_clip <= r_clip | q.clip;
            unique case (r_step)
                S_DTSIG: r_dt_sig <= q.val;
                S_CONV:  r_conv   <= q.val;
                S_DX2:   r_dx2    <= q.val;
                S_REACT: r_react  <= q.val;
                S_PA:    r_pa     <= q.val;
                S_PB:    r_pb     <= q.val;
                S_SCL:   r_acc    <= q.val;
                default: r_tmp    <= q.val;
            endcase
        end
        if (add_wr) begin
            unique case (r_step)
                S_AG: begin
                    r_alpha <= s_alpha.val;
                    r_gamma <= s_gamma.val;
                    r_clip  <= r_clip | s_alpha.clip | s_gamma.clip;
                end
                S_BETA1: begin
                    r_beta <= s_beta1.val;
                    r_clip <= r_clip | s_beta1.clip;
                end
                S_BETA2: begin
                    r_beta <= s_beta2.val;
                    r_clip <= r_clip | s_beta2.clip;
                end
                default: begin
                    r_acc  <= s_acc.val;
                    r_clip <= r_clip | s_acc.clip;
                end
            endcase
        end
        if (r_busy && (r_step == S_RES) && out_free) begin
            r_out_val  <= s_res.val;
            r_out_idx  <= r_job.index;
            r_out_last <= r_job.last;
            r_out_sat  <= r_clip | s_res.clip;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_new_value   = r_out_val;
    assign o_point_index = r_out_idx;
    assign o_sweep_end   = r_out_last;
    assign o_saturated   = r_out_sat;

    `ASSERT_IMPL(a_start, i_clk, i_rst_n, o_pop |=> r_busy && r_step == S_DTSIG && !r_phase, "bad start")
    `ASSERT_NEVER(a_phase_on_add, i_clk, i_rst_n, r_busy && r_phase && !is_mul, "phase on add")

endmodule

@@ rtl/core/explicit_euler_stencil_sweep_top.sv @@
// Channel   Dir  Handshake                       Payload
// s_axis    in   s_axis_tvalid / s_axis_tready   tdata: old_value, diffusion, convection,
//                                                reaction, forcing; tlast: last_point
// m_axis    out  m_axis_tvalid / m_axis_tready   tdata: new_value, point_index;
//                                                tlast: sweep_end; tuser: saturated
// cfg       in   i_cfg_we                        i_cfg_idx, i_cfg_wdata
//
// For each inner point the back end picks up a job, then runs 13 multiplies, each with its
// product registered, on one shared 32x32 multiplier, and 5 saturating add steps.
// The first two points of a sweep only fill the window and give no result.
// A two-entry job queue lets the front keep taking points while the back end computes.
// Reset is synchronous, active low, and restores the register defaults.
// A stalled output holds its result; the back end then waits with the next result ready.
module explicit_euler_stencil_sweep_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // old_value[31:0], diffusion[63:32], convection[95:64], reaction[127:96],
    // forcing[159:128]
    input  logic [159:0]                      s_axis_tdata,
    input  logic                              s_axis_tlast,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // new_value[31:0], point_index[41:32], zero[47:42]
    output logic [47:0]                       m_axis_tdata,
    output logic                              m_axis_tlast,
    // saturated[0]
    output logic                              m_axis_tuser,
    input  logic                              i_cfg_we,
    input  logic [eess_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [eess_pkg::CFG_W-1:0]        i_cfg_wdata
);
    import eess_pkg::*;

    t_cfg             r_cfg;
    t_point           pt;
    t_job             push_job, head_job;
    logic             push, full, pop, empty;
    t_val             new_value;
    logic [IDX_W-1:0] point_index;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.time_step  <= RST_TIME_STEP;
            r_cfg.space_step <= RST_SPACE_STEP;
            r_cfg.inv_sq     <= RST_INV_SQ;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_TIME_STEP:  r_cfg.time_step  <= i_cfg_wdata;
                CFG_SPACE_STEP: r_cfg.space_step <= i_cfg_wdata;
                CFG_INV_SQ:     r_cfg.inv_sq     <= i_cfg_wdata;
                default:        ;
            endcase
        end
    end

    always_comb begin
        pt.old_value  = t_val'(s_axis_tdata[31:0]);
        pt.diffusion  = t_val'(s_axis_tdata[63:32]);
        pt.convection = t_val'(s_axis_tdata[95:64]);
        pt.reaction   = t_val'(s_axis_tdata[127:96]);
        pt.forcing    = t_val'(s_axis_tdata[159:128]);
        pt.last_point = s_axis_tlast;
    end

    eess_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_pt    (pt),
        .i_full  (full),
        .o_push  (push),
        .o_job   (push_job)
    );

    eess_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .o_full  (full),
        .i_pop   (pop),
        .o_job   (head_job),
        .o_empty (empty)
    );

    eess_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_empty       (empty),
        .i_job         (head_job),
        .o_pop         (pop),
        .o_valid       (m_axis_tvalid),
        .i_ready       (m_axis_tready),
        .o_new_value   (new_value),
        .o_point_index (point_index),
        .o_sweep_end   (m_axis_tlast),
        .o_saturated   (m_axis_tuser)
    );

    assign m_axis_tdata = {6'b0, point_index, new_value};

endmodule
